// ===== rtl/nrffa_pkg.sv =====
`timescale 1ns / 1ps

package nrffa_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int NODES_DEF    = 8;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_W       = 32;
  localparam int SIZE_W      = 31;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int SLOTS_CFG_W = 5;
  localparam int NODE_CFG_W  = 3;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_SIZE    = 2'd2;
  localparam logic [1:0] CMD_LARGEST = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OTHER_SIZE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_GAP     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP   = 3'd4;

  typedef enum logic [2:0] {
    VAL_ZERO  = 3'd0,
    VAL_START = 3'd1,
    VAL_LEN   = 3'd2,
    VAL_BEST  = 3'd3,
    VAL_OFF   = 3'd4
  } val_sel_t;

  typedef struct packed {
    logic                accept;
    logic                idx_clr;
    logic                idx_inc;
    logic                gap_init;
    logic                probe_init;
    logic                take_end;
    logic                av_upd;
    logic                gap_adv;
    logic                best_upd;
    logic                wr_join;
    logic                wr_free;
    logic                wr_new;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    val_sel_t            res_val_sel;
    logic                res_fresh;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       size_zero;
    logic       idx_end;
    logic       key_hit;
    logic       size_eq;
    logic       ovl_hit;
    logic       off_lt_end;
    logic       fit;
    logic       slot_dead;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/nrffa_dp.sv =====
`timescale 1ns / 1ps

module nrffa_dp import nrffa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int NODES    = NODES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_command,
  input  logic [KEY_W-1:0]      in_name_key,
  input  logic [SIZE_W-1:0]     in_request_size,
  input  logic                  in_dirty,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SIZE_W-1:0]     out_value,
  output logic                  out_fresh,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int NW   = (CNTW > SLOTS_CFG_W) ? CNTW : SLOTS_CFG_W;
  localparam logic [31:0] END_MAX = 32'h8000_0000;

  function automatic logic [3:0] node_mod(input logic [NODE_CFG_W-1:0] node);
    logic [3:0] v;
    v = {1'b0, node};
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= NODES) v = v - 4'(NODES);
    end
    return v;
  endfunction

  logic [SIZE_W-1:0]     base_r, len_r;
  logic [CNTW-1:0]       n_r;
  logic [NODE_CFG_W-1:0] node_r;
  logic                  keep_r;
  logic [NW-1:0]         n_req;
  logic [CNTW-1:0]       n_cfg;

  assign n_req = NW'(cfg_data[SLOTS_CFG_W-1:0]);
  assign n_cfg = (n_req > NW'(SLOTS)) ? CNTW'(SLOTS) : n_req[CNTW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      len_r  <= '0;
      n_r    <= CNTW'(SLOTS);
      node_r <= '0;
      keep_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE:   base_r <= cfg_data;
        CFG_LENGTH: len_r  <= cfg_data;
        CFG_SLOTS:  n_r    <= n_cfg;
        CFG_NODE:   node_r <= cfg_data[NODE_CFG_W-1:0];
        CFG_KEEP:   keep_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [1:0]        cmd_r;
  logic [KW-1:0]     key_r;
  logic [SIZE_W-1:0] size_r;
  logic              dirty_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_command;
      key_r   <= in_name_key[KW-1:0];
      size_r  <= in_request_size;
      dirty_r <= in_dirty;
    end
  end

  logic [CNTW-1:0] idx_r;
  logic [IW-1:0]   a;
  assign a = idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNTW'(1);
    end
  end

  logic [KW-1:0]     key_mem   [SLOTS];
  logic [SIZE_W-1:0] len_mem   [SLOTS];
  logic [SIZE_W-1:0] start_mem [SLOTS];
  logic [NODES-1:0]  own_mem   [SLOTS];
  logic [KW-1:0]     rd_key_q;
  logic [SIZE_W-1:0] rd_len_q, rd_start_q;
  logic [NODES-1:0]  rd_own_q;
  logic [SLOTS-1:0]  live_r;

  logic [NODES-1:0] node_bit;
  logic [NODES-1:0] own_wd;
  logic             own_we;
  logic [31:0]      off_r, av_r;
  logic [SIZE_W-1:0] best_r;

  assign node_bit = NODES'(1) << node_mod(node_r);
  assign own_we   = cmd.wr_join | cmd.wr_free | cmd.wr_new;

  always_comb begin
    if (cmd.wr_new) begin
      own_wd = node_bit;
    end else if (cmd.wr_join) begin
      own_wd = rd_own_q | node_bit;
    end else begin
      own_wd = (rd_own_q & ~node_bit) | ((keep_r && dirty_r) ? node_bit : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      key_mem[a]   <= key_r;
      len_mem[a]   <= size_r;
      start_mem[a] <= off_r[SIZE_W-1:0];
    end
    if (own_we) own_mem[a] <= own_wd;
    rd_key_q   <= key_mem[a];
    rd_len_q   <= len_mem[a];
    rd_start_q <= start_mem[a];
    rd_own_q   <= own_mem[a];
  end

  // Owners are only read for live slots, so one flop per slot covers reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (own_we) begin
      live_r[a] <= |own_wd;
    end
  end

  logic [31:0]       end_sum, end_w, seg_end, gap_dist;
  logic [32:0]       o_want;
  logic [SIZE_W-1:0] want;
  logic              live_cur, closer;

  assign end_sum  = {1'b0, base_r} + {1'b0, len_r};
  assign end_w    = (end_sum > END_MAX) ? END_MAX : end_sum;
  assign want     = (cmd_r == CMD_LARGEST) ? SIZE_W'(1) : size_r;
  assign o_want   = {1'b0, off_r} + 33'(want);
  assign seg_end  = {1'b0, rd_start_q} + {1'b0, rd_len_q};
  assign gap_dist = {1'b0, rd_start_q} - off_r;
  assign live_cur = live_r[a];
  assign closer   = live_cur && ({1'b0, rd_start_q} >= off_r) && (gap_dist < av_r);

  always_ff @(posedge clk) begin
    if (cmd.gap_init) begin
      off_r  <= {1'b0, base_r};
      best_r <= '0;
    end else begin
      if (cmd.probe_init) av_r <= end_w - off_r;
      if (cmd.av_upd && closer) av_r <= gap_dist;
      if (cmd.take_end) off_r <= seg_end;
      if (cmd.gap_adv) off_r <= off_r + av_r;
      if (cmd.best_upd && (av_r > {1'b0, best_r})) best_r <= av_r[SIZE_W-1:0];
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.size_zero  = (size_r == '0);
  assign stat.idx_end    = (idx_r == n_r);
  assign stat.key_hit    = live_cur && (rd_key_q == key_r);
  assign stat.size_eq    = (rd_len_q == size_r);
  assign stat.ovl_hit    = live_cur && (o_want > 33'(rd_start_q)) && (off_r < seg_end);
  assign stat.off_lt_end = (off_r < end_w);
  assign stat.fit        = ({1'b0, size_r} <= av_r);
  assign stat.slot_dead  = !live_cur;
  assign stat.out_free   = !out_valid || !out_stall;

  logic [STATUS_W-1:0] res_status_r;
  logic [SIZE_W-1:0]   res_value_r;
  logic                res_fresh_r;
  logic [SIZE_W-1:0]   res_val;

  always_comb begin
    case (cmd.res_val_sel)
      VAL_START: res_val = rd_start_q;
      VAL_LEN:   res_val = rd_len_q;
      VAL_BEST:  res_val = best_r;
      VAL_OFF:   res_val = off_r[SIZE_W-1:0];
      default:   res_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= res_val;
      res_fresh_r  <= cmd.res_fresh;
    end
    if (cmd.out_load) begin
      out_status <= res_status_r;
      out_value  <= res_value_r;
      out_fresh  <= res_fresh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/nrffa_ctrl.sv =====
`timescale 1ns / 1ps

module nrffa_ctrl import nrffa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_FK_RD    = 10'b00_0000_0100,
    S_FK_EV    = 10'b00_0000_1000,
    S_GAP_INIT = 10'b00_0001_0000,
    S_GAP_TOP  = 10'b00_0010_0000,
    S_PR_RD    = 10'b00_0100_0000,
    S_PR_EV    = 10'b00_1000_0000,
    S_SL_EV    = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.cmd == CMD_ALLOC && stat.size_zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_ZERO;
          state_nxt      = S_DONE;
        end else if (stat.cmd == CMD_LARGEST) begin
          state_nxt = S_GAP_INIT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_FK_RD;
        end
      end
      S_FK_RD: state_nxt = S_FK_EV;
      S_FK_EV: begin
        if (stat.idx_end) begin
          if (stat.cmd == CMD_ALLOC) begin
            state_nxt = S_GAP_INIT;
          end else begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end else if (stat.key_hit) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
          case (stat.cmd)
            CMD_ALLOC: begin
              if (stat.size_eq) begin
                cmd.wr_join     = 1'b1;
                cmd.res_val_sel = VAL_START;
              end else begin
                cmd.res_status = ST_OTHER_SIZE;
              end
            end
            CMD_FREE: cmd.wr_free = 1'b1;
            default:  cmd.res_val_sel = VAL_LEN;
          endcase
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_FK_RD;
        end
      end
      S_GAP_INIT: begin
        cmd.gap_init = 1'b1;
        state_nxt    = S_GAP_TOP;
      end
      S_GAP_TOP: begin
        if (!stat.off_lt_end) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
          if (stat.cmd == CMD_LARGEST) begin
            cmd.res_val_sel = VAL_BEST;
          end else begin
            cmd.res_status = ST_NO_GAP;
          end
        end else begin
          cmd.probe_init = 1'b1;
          cmd.idx_clr    = 1'b1;
          state_nxt      = S_PR_RD;
        end
      end
      S_PR_RD: state_nxt = S_PR_EV;
      S_PR_EV: begin
        if (stat.idx_end) begin
          // No region overlaps the candidate: the gap length is known.
          if (stat.cmd == CMD_LARGEST) begin
            cmd.best_upd = 1'b1;
            cmd.gap_adv  = 1'b1;
            state_nxt    = S_GAP_TOP;
          end else if (!stat.fit) begin
            cmd.gap_adv = 1'b1;
            state_nxt   = S_GAP_TOP;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SL_EV;
          end
        end else if (stat.ovl_hit) begin
          cmd.take_end = 1'b1;
          state_nxt    = S_GAP_TOP;
        end else begin
          cmd.av_upd  = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_PR_RD;
        end
      end
      S_SL_EV: begin
        if (stat.idx_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_SLOT;
          state_nxt      = S_DONE;
        end else if (stat.slot_dead) begin
          cmd.wr_new      = 1'b1;
          cmd.res_set     = 1'b1;
          cmd.res_val_sel = VAL_OFF;
          cmd.res_fresh   = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/named_region_first_fit_allocator.sv =====
`timescale 1ns / 1ps

// Named region allocator: a table of SLOTS regions inside one address window.
// Input channel (in_valid / in_stall) takes one request word: command, name key,
// requested size and dirty flag. Output channel (out_valid / out_stall) returns
// one word per request: status, value and the fresh flag.
// The cfg_ port writes window base, window length, slots searched, node number
// and keep-dirty mode; write it only while the block is idle.
// Allocate, free and size requests first do a key lookup over the searched
// slots, one slot at a time. An allocate that misses, and the largest-gap query,
// rerun a probe over all searched slots for every candidate gap, then allocate
// scans slot liveness one slot at a time. Search time is set by the single read
// port of the slot table. One request is in work at a time; the next is taken
// while a finished word waits at the output.
// Reset kills all slots and loads the register defaults. A stalled output
// word holds; the block finishes the next request and then waits.
module named_region_first_fit_allocator import nrffa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int NODES    = NODES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [KEY_W-1:0]      in_name_key,
  input  logic [SIZE_W-1:0]     in_request_size,
  input  logic                  in_dirty,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SIZE_W-1:0]     out_value,
  output logic                  out_fresh,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nrffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  nrffa_dp #(
    .SLOTS    (SLOTS),
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_name_key     (in_name_key),
    .in_request_size (in_request_size),
    .in_dirty        (in_dirty),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_fresh       (out_fresh),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ===== rtl/nrffa_checker.sv =====
`timescale 1ns / 1ps

module nrffa_checker import nrffa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [SIZE_W-1:0]   out_value,
  input logic                out_fresh
);

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_value)
                               && $stable(out_fresh))
    else $error("stalled output word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0 && !out_fresh)
    else $error("failed request carries a value or fresh flag");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NOT_FOUND)
    else $error("status code out of range");

endmodule

bind named_region_first_fit_allocator nrffa_checker u_nrffa_checker (.*);

// ===== verif/named_region_first_fit_allocator_tb.sv =====
`timescale 1ns / 1ps

module named_region_first_fit_allocator_tb;
  import nrffa_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int CYCLE_LIMIT = 12000000;
  localparam longint unsigned WIN_TOP = 64'h8000_0000;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   value;
    logic                fresh;
  } region_answer_t;

  // Mirror of the region table plus the register file, and the store of answers
  // the block still owes.
  class region_table_sb;
    logic [KEY_W-1:0]  key_q[NUM_SLOTS];
    logic [SIZE_W-1:0] len_q[NUM_SLOTS];
    logic [SIZE_W-1:0] start_q[NUM_SLOTS];
    logic [7:0]        owners_q[NUM_SLOTS];
    logic [SIZE_W-1:0] win_base, win_len;
    logic [4:0]        slot_lim;
    logic [2:0]        node;
    logic              keep_mode;
    region_answer_t    owed[$];
    int                bad;

    function void clear();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        key_q[i] = '0; len_q[i] = '0; start_q[i] = '0; owners_q[i] = '0;
      end
      win_base = '0; win_len = '0; slot_lim = 5'(NUM_SLOTS); node = '0; keep_mode = 1'b0;
      owed.delete();
      bad = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE:   win_base = data;
        CFG_LENGTH: win_len = data;
        CFG_SLOTS:  slot_lim = data[4:0];
        CFG_NODE:   node = data[2:0];
        CFG_KEEP:   keep_mode = data[0];
        default: ;
      endcase
    endfunction

    function int span();
      return (slot_lim > NUM_SLOTS) ? NUM_SLOTS : int'(slot_lim);
    endfunction

    function bit is_live(int i);
      return len_q[i] != 0 && owners_q[i] != 0;
    endfunction

    function int lookup(logic [KEY_W-1:0] key);
      for (int i = 0; i < span(); i++)
        if (is_live(i) && key_q[i] == key) return i;
      return -1;
    endfunction

    // Returns 1 and moves off past a live region that [off, off+want) overlaps;
    // otherwise gives the free run starting at off.
    function bit collides(inout u64_t off, input u64_t want, output u64_t avail,
                          input u64_t fin);
      u64_t av, s, e;
      av = fin - off;
      avail = 0;
      for (int i = 0; i < span(); i++) begin
        if (!is_live(i)) continue;
        s = start_q[i];
        e = s + len_q[i];
        if (off + want > s && off < e) begin
          off = e;
          return 1'b1;
        end
        if (s >= off && s - off < av) av = s - off;
      end
      avail = av;
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                               logic [SIZE_W-1:0] size, logic dirty);
      region_answer_t r;
      u64_t fin, off, av, best;
      int k, j;
      logic [7:0] nb;
      r.status = ST_OK; r.value = '0; r.fresh = 1'b0;
      fin = u64_t'(win_base) + u64_t'(win_len);
      if (fin > WIN_TOP) fin = WIN_TOP;
      nb = 8'(1) << node;
      case (cmd)
        CMD_ALLOC: begin
          k = lookup(key);
          if (size == 0) r.status = ST_ZERO;
          else if (k >= 0) begin
            if (len_q[k] == size) begin
              owners_q[k] = owners_q[k] | nb;
              r.value = start_q[k];
            end else r.status = ST_OTHER_SIZE;
          end else begin
            off = win_base;
            r.status = ST_NO_GAP;
            while (off < fin) begin
              if (collides(off, u64_t'(size), av, fin)) continue;
              if (u64_t'(size) > av) begin
                off += av;
                continue;
              end
              j = 0;
              while (j < span() && is_live(j)) j++;
              if (j == span()) begin
                r.status = ST_NO_SLOT;
                break;
              end
              key_q[j] = key; len_q[j] = size; start_q[j] = off[30:0]; owners_q[j] = nb;
              r.status = ST_OK; r.value = off[30:0]; r.fresh = 1'b1;
              break;
            end
          end
        end
        CMD_FREE: begin
          k = lookup(key);
          if (k < 0) r.status = ST_NOT_FOUND;
          else if (!(keep_mode && dirty)) owners_q[k] = owners_q[k] & ~nb;
          // A dirty free in keep mode sets the owner bit rather than clearing it.
          else owners_q[k] = owners_q[k] | nb;
        end
        CMD_SIZE: begin
          k = lookup(key);
          if (k < 0) r.status = ST_NOT_FOUND;
          else r.value = len_q[k];
        end
        default: begin
          off = win_base;
          best = 0;
          while (off < fin) begin
            if (!collides(off, 1, av, fin)) begin
              if (av > best) best = av;
              off += av;
            end
          end
          r.value = best[30:0];
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SIZE_W-1:0] value,
                               logic fresh);
      region_answer_t e;
      if (owed.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("unexpected word: status %0d value %0h fresh %0b", status, value, fresh);
        return;
      end
      e = owed.pop_front();
      if (e.status !== status || e.value !== value || e.fresh !== fresh) begin
        bad++;
        if (bad <= 10)
          $display("mismatch: expected status %0d value %0h fresh %0b, got %0d %0h %0b",
                   e.status, e.value, e.fresh, status, value, fresh);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_command = CMD_ALLOC;
  logic [KEY_W-1:0]      in_name_key = '0;
  logic [SIZE_W-1:0]     in_request_size = '0;
  logic                  in_dirty = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [SIZE_W-1:0]     out_value;
  logic                  out_fresh;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  region_table_sb sb = new();
  int hold_cycles = 0;
  int burst_left = 0;
  bit gapless = 1'b0;
  int cycles = 0;
  logic [KEY_W-1:0] key_pool[8];
  logic [SIZE_W-1:0] size_pool[8];

  named_region_first_fit_allocator uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_value, out_fresh);

  // Receiver: a counter picks a new random stall pattern each time it runs out; a long hold overrides it.
  initial begin
    int mode, count;
    mode = 0;
    count = 0;
    forever begin
      @(negedge clk);
      if (count == 0) begin
        mode = $urandom_range(0, 3);
        count = 200;
      end
      count--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= (count % 3 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end
  end

  task automatic send_req(logic [1:0] cmd, logic [KEY_W-1:0] key,
                          logic [SIZE_W-1:0] size, logic dirty);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_command <= cmd;
    in_name_key <= key;
    in_request_size <= size;
    in_dirty <= dirty;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, key, size, dirty);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_window(logic [30:0] base, logic [30:0] len, logic [4:0] lim,
                            logic [2:0] nd, logic keep);
    drain();
    write_reg(CFG_BASE, base);
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_SLOTS, 31'(lim));
    write_reg(CFG_NODE, 31'(nd));
    write_reg(CFG_KEEP, 31'(keep));
  endtask

  task automatic random_req();
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [SIZE_W-1:0] size;
    int p, pick;
    u64_t cap;
    p = $urandom_range(0, 7);
    pick = $urandom_range(0, 99);
    cmd = (pick < 40) ? CMD_ALLOC : (pick < 70) ? CMD_FREE : (pick < 85) ? CMD_SIZE
        : CMD_LARGEST;
    key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[p];
    cap = sb.win_len / 6;
    if (cap < 100) cap = 100;
    pick = $urandom_range(0, 99);
    if (pick < 50) size = size_pool[p];
    else if (pick < 88) size = 31'($urandom_range(1, int'(cap > 32'h7fff_ffff ? 32'h7fff_ffff : cap)));
    else if (pick < 95) size = 31'($urandom);
    else size = '0;
    send_req(cmd, key, size, 1'($urandom));
  endtask

  initial begin
    logic [30:0] base, len;
    sb.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty window at reset defaults.
    send_req(CMD_ALLOC, 32'h11, 31'd10, 1'b0);
    send_req(CMD_LARGEST, 32'h0, 31'd0, 1'b0);
    send_req(CMD_FREE, 32'h11, 31'd0, 1'b0);
    send_req(CMD_SIZE, 32'h11, 31'd0, 1'b0);
    send_req(CMD_ALLOC, 32'h11, 31'd0, 1'b0);

    set_window(31'd100, 31'd1000, 5'd16, 3'd0, 1'b0);
    send_req(CMD_ALLOC, 32'h11, 31'd100, 1'b0);
    send_req(CMD_ALLOC, 32'h11, 31'd100, 1'b0);
    send_req(CMD_ALLOC, 32'h11, 31'd50, 1'b0);
    send_req(CMD_ALLOC, 32'h22, 31'd2000, 1'b0);
    send_req(CMD_ALLOC, 32'h22, 31'h7FFF_FFFF, 1'b1);
    send_req(CMD_SIZE, 32'h11, 31'd0, 1'b0);
    send_req(CMD_ALLOC, 32'hFFFF_FFFF, 31'd300, 1'b0);
    send_req(CMD_LARGEST, 32'h0, 31'h7FFF_FFFF, 1'b0);
    send_req(CMD_FREE, 32'h11, 31'd0, 1'b1);
    send_req(CMD_SIZE, 32'h11, 31'd0, 1'b0);
    send_req(CMD_ALLOC, 32'h33, 31'd50, 1'b0);

    // Two slots searched, both live: a fitting gap finds no free slot.
    set_window(31'd100, 31'd1000, 5'd2, 3'd0, 1'b0);
    send_req(CMD_ALLOC, 32'h44, 31'd10, 1'b0);

    set_window(31'd100, 31'd1000, 5'd20, 3'd7, 1'b1);
    send_req(CMD_FREE, 32'h33, 31'd0, 1'b1);
    send_req(CMD_FREE, 32'h33, 31'd0, 1'b0);
    send_req(CMD_SIZE, 32'h33, 31'd0, 1'b0);

    // Window that runs past the top of the address space.
    set_window(31'h7FFF_FF00, 31'h7FFF_FFFF, 5'd16, 3'd7, 1'b0);
    send_req(CMD_ALLOC, 32'h55, 31'h100, 1'b0);
    send_req(CMD_LARGEST, 32'h0, 31'd0, 1'b0);

    set_window(31'd0, 31'h7FFF_FFFF, 5'd0, 3'd2, 1'b0);
    send_req(CMD_ALLOC, 32'h66, 31'd5, 1'b0);
    send_req(CMD_SIZE, 32'h66, 31'd0, 1'b0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin base = '0; len = 31'h7FFF_FFFF; end
        1: begin base = 31'($urandom_range(0, 1000)); len = 31'($urandom_range(64, 5000)); end
        2: begin base = 31'h7FFF_F000 + 31'($urandom_range(0, 255)); len = 31'h7FFF_FFFF; end
        default: begin base = 31'($urandom); len = 31'($urandom); end
      endcase
      set_window(base, len, (ph == 5) ? 5'd31 : 5'($urandom_range(ph == 1 ? 4 : 0, 20)),
                 3'($urandom), 1'($urandom));
      for (int i = 0; i < 8; i++) begin
        key_pool[i] = $urandom;
        size_pool[i] = 31'($urandom_range(1, (len / 8 > 1000) ? 1000 : int'(len / 8) + 1));
      end
      gapless = (ph == 3);
      // The block holds one finished word and one in work, then stalls input.
      if (ph == 2) hold_cycles = 3000;
      for (int i = 0; i < PHASE_ITEMS; i++) random_req();
    end

    drain();
    if (sb.bad == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nrffa_pkg.sv
rtl/nrffa_dp.sv
rtl/nrffa_ctrl.sv
rtl/named_region_first_fit_allocator.sv
rtl/nrffa_checker.sv
verif/named_region_first_fit_allocator_tb.sv
